[rtl/gae_pkg.sv]
`default_nettype none
package gae_pkg;
  localparam int FRAC_BITS_DEF = 16;
  localparam int TOTAL_WIDTH_DEF = 48;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_TRUNC = 2'd2,
    KIND_SPARE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_DISCOUNT = 2'd0,
    REG_DECAY    = 2'd1,
    REG_RECIP    = 2'd2,
    REG_CLIP     = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

[rtl/gae_ctrl.sv]
`default_nettype none
module gae_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_fire,
  input  wire             out_free,
  input  gae_pkg::stat_t  stat,
  output logic            busy,
  output gae_pkg::cmd_t   cmd
);
  gae_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= gae_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gae_pkg::ST_IDLE: if (in_fire) state_nxt = gae_pkg::ST_MUL;
      gae_pkg::ST_MUL:  state_nxt = gae_pkg::ST_ACC;
      gae_pkg::ST_ACC:  state_nxt = stat.last ? gae_pkg::ST_DIV : gae_pkg::ST_OUT;
      gae_pkg::ST_DIV:  if (stat.div_done) state_nxt = gae_pkg::ST_OUT;
      gae_pkg::ST_OUT:  if (out_free) state_nxt = gae_pkg::ST_IDLE;
      default:          state_nxt = gae_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      gae_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.load = in_fire;
      end
      gae_pkg::ST_MUL: cmd.mul = 1'b1;
      gae_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        cmd.div_start = stat.last;
      end
      gae_pkg::ST_DIV: cmd.div_step = 1'b1;
      gae_pkg::ST_OUT: cmd.out_load = out_free;
      default: ;
    endcase
  end

  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !cmd.load) else $error("load repeated");
  a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> !busy) else $error("not idle after output");
  a_div_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> stat.last) else $error("divide without last");
endmodule
`default_nettype wire

[rtl/gae_dp.sv]
`default_nettype none
module gae_dp #(
  parameter int TOTAL_WIDTH = gae_pkg::TOTAL_WIDTH_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  gae_pkg::cmd_t         cmd,
  output gae_pkg::stat_t        stat,
  input  wire                   cfg_we,
  input  wire  [1:0]            cfg_idx,
  input  wire  [30:0]           cfg_data,
  input  wire  signed [31:0]    reward,
  input  wire  [1:0]            kind,
  input  wire  signed [31:0]    vpred,
  input  wire  signed [31:0]    npred,
  input  wire  signed [31:0]    tpred,
  input  wire                   first,
  input  wire                   last,
  output logic [31:0]           adv_o,
  output logic [31:0]           ret_o,
  output logic [31:0]           tgt_o,
  output logic [16:0]           frac_o,
  output logic                  last_o
);
  localparam int FRAC_BITS = gae_pkg::FRAC_BITS_DEF;
  localparam int TW = TOTAL_WIDTH;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] SMAX = 64'sd2147483647;
  localparam logic signed [63:0] SMIN = -64'sd2147483648;
  localparam logic [TW-1:0] TMAX = '1;
  localparam int CW = $clog2(FRAC_BITS + 2);

  function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
    rnd = (p + HALF) >>> FRAC_BITS;
  endfunction
  function automatic logic signed [31:0] sat(input logic signed [63:0] v);
    if (v > SMAX) sat = 32'sh7fffffff;
    else if (v < SMIN) sat = 32'sh80000000;
    else sat = v[31:0];
  endfunction
  function automatic logic [TW-1:0] tadd(input logic [TW-1:0] t, input logic [32:0] v);
    logic [TW:0] s;
    s = {1'b0, t} + {{(TW-32){1'b0}}, v};
    tadd = s[TW] ? TMAX : s[TW-1:0];
  endfunction

  logic [16:0] gamma_r, lambda_r;
  logic [30:0] recip_r, clip_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= 17'd65208; lambda_r <= 17'd62259; recip_r <= '0; clip_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        gae_pkg::REG_DISCOUNT: gamma_r <= cfg_data[16:0];
        gae_pkg::REG_DECAY:    lambda_r <= cfg_data[16:0];
        gae_pkg::REG_RECIP:    recip_r <= cfg_data;
        default:               clip_r <= cfg_data;
      endcase
    end
  end

  logic signed [31:0] rew_r, vp_r, nx_r, radv_r, rret_r;
  logic term_r, last_r, first_r;
  logic signed [63:0] srw_r, gnx_r, rg_r;
  logic [16:0] gl_r;
  logic [TW-1:0] tot_r, clp_r;
  logic signed [31:0] adv_r, ret_r, tgt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rew_r <= reward; vp_r <= vpred;
      nx_r <= (kind == gae_pkg::KIND_TRUNC) ? tpred :
              (kind == gae_pkg::KIND_DONE) ? 32'sd0 : npred;
      term_r <= (kind == gae_pkg::KIND_TRUNC) || (kind == gae_pkg::KIND_DONE);
      last_r <= last; first_r <= first;
    end
  end

  // stage 1: independent products
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      srw_r <= rnd(64'(rew_r) * $signed({1'b0, recip_r}));
      gnx_r <= rnd(64'(nx_r) * $signed({1'b0, gamma_r}));
      gl_r  <= 17'(rnd($signed({47'd0, gamma_r}) * $signed({47'd0, lambda_r})));
      rg_r  <= rnd(64'(first_r ? 32'sd0 : rret_r) * $signed({1'b0, gamma_r}));
    end
  end

  logic signed [31:0] s_std, s_cl, ra;
  logic signed [63:0] delta, gla, advw;
  logic [32:0] a_raw, a_cl;
  logic [TW-1:0] tb, cb;
  logic signed [31:0] adv_n, ret_n;
  always_comb begin
    s_std = (recip_r != '0) ? sat(srw_r) : rew_r;
    s_cl = s_std;
    if (recip_r != '0 && clip_r != '0) begin
      if (64'(s_std) > $signed({33'd0, clip_r})) s_cl = $signed({1'b0, clip_r});
      if (64'(s_std) < -$signed({33'd0, clip_r})) s_cl = -$signed({1'b0, clip_r});
    end
    a_raw = s_std[31] ? 33'(-34'(s_std)) : 33'(s_std);
    a_cl  = s_cl[31] ? 33'(-34'(s_cl)) : 33'(s_cl);
    tb = first_r ? '0 : tot_r;
    cb = first_r ? '0 : clp_r;
    ra = first_r ? 32'sd0 : radv_r;
    delta = 64'(s_cl) + gnx_r - 64'(vp_r);
    gla = rnd($signed({1'b0, gl_r}) * 64'(ra));
    advw = term_r ? delta : delta + gla;
    adv_n = sat(advw);
    ret_n = term_r ? rew_r : sat(64'(rew_r) + rg_r);
  end

  logic [TW-1:0] den_r, rem_r;
  logic [FRAC_BITS:0] q_r;
  logic [CW-1:0] cnt_r;
  logic [TW:0] rsh;
  always_comb rsh = {rem_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radv_r <= '0; rret_r <= '0; tot_r <= '0; clp_r <= '0;
    end else if (cmd.acc) begin
      radv_r <= adv_n; rret_r <= ret_n;
      tot_r <= tadd(tb, a_raw); clp_r <= tadd(cb, a_cl);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      adv_r <= adv_n; ret_r <= ret_n;
      tgt_r <= sat(64'(vp_r) + 64'(adv_n));
      q_r <= '0;
    end
    if (cmd.div_start) begin
      den_r <= tadd(tb, a_raw);
      rem_r <= tadd(tb, a_raw) - tadd(cb, a_cl);
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      if (cnt_r == '0) begin
        if (den_r == '0) begin
          q_r <= '0; cnt_r <= CW'(FRAC_BITS + 1);
        end else begin
          q_r <= {{FRAC_BITS{1'b0}}, rem_r >= den_r};
          if (rem_r >= den_r) rem_r <= rem_r - den_r;
          cnt_r <= cnt_r + 1'b1;
        end
      end else if (cnt_r != CW'(FRAC_BITS + 1)) begin
        q_r <= {q_r[FRAC_BITS-1:0], rsh >= {1'b0, den_r}};
        rem_r <= (rsh >= {1'b0, den_r}) ? TW'(rsh - {1'b0, den_r}) : rsh[TW-1:0];
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_comb begin
    stat.last = last_r;
    stat.div_done = cmd.div_step && (cnt_r == CW'(FRAC_BITS)
                    || cnt_r == CW'(FRAC_BITS + 1));
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      adv_o <= adv_r; ret_o <= ret_r; tgt_o <= tgt_r;
      frac_o <= last_r ? 17'(q_r) : 17'd0;
      last_o <= last_r;
    end
  end
endmodule
`default_nettype wire

[rtl/generalized_advantage_estimator_unit.sv]
// Generalized advantage estimator, fixed point.
// Input stream in_*: one trajectory step per transfer, in reverse time order.
// Output stream out_*: one result per step; tlast marks the final step's
// result, which also carries the clip fraction.
// Config: cfg_we/cfg_idx/cfg_wdata write gamma, lambda, reward scale, clip.
// Write config only while idle.
// After accept, an item is loaded, multiplied and accumulated. The last
// item of a batch then runs the bit-serial fraction divider (one setup
// step plus one step per fraction bit), which stops early when its
// absolute-reward total is zero.
// One item is in work at a time; a new item is taken the cycle after the
// previous result enters the output register.
// A stalled receiver holds the result; the next item waits finished and
// in_tready stays low until the output register frees.
// Reset clears running state, totals and restores register defaults.
`default_nettype none
module generalized_advantage_estimator_unit #(
  parameter int TOTAL_WIDTH = gae_pkg::TOTAL_WIDTH_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          cfg_we,
  input  wire  [1:0]   cfg_idx,
  input  wire  [30:0]  cfg_wdata,
  input  wire          in_tvalid,
  output logic         in_tready,
  // reward[31:0], value_pred[63:32], next_value_pred[95:64], trunc_value_pred[127:96]
  input  wire  [127:0] in_tdata,
  // terminal_kind[1:0], first_item[2]
  input  wire  [2:0]   in_tuser,
  input  wire          in_tlast,
  output logic         out_tvalid,
  input  wire          out_tready,
  // advantage[31:0], discounted_return[63:32], target_value[95:64],
  // clip_fraction[112:96], zero fill[119:113]
  output logic [119:0] out_tdata,
  output logic         out_tlast
);
  gae_pkg::cmd_t cmd;
  gae_pkg::stat_t stat;
  logic busy, vld_r, out_free;
  logic [31:0] a, r, t;
  logic [16:0] f;

  assign out_free = !vld_r || out_tready;
  assign in_tready = !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (cmd.out_load) vld_r <= 1'b1;
    else if (out_tready) vld_r <= 1'b0;
  end

  gae_ctrl u_ctrl (.clk, .rst_n, .in_fire(in_tvalid && in_tready), .out_free,
    .stat, .busy, .cmd);

  gae_dp #(.TOTAL_WIDTH(TOTAL_WIDTH)) u_dp (
    .clk, .rst_n, .cmd, .stat, .cfg_we, .cfg_idx, .cfg_data(cfg_wdata),
    .reward(in_tdata[31:0]), .kind(in_tuser[1:0]), .vpred(in_tdata[63:32]),
    .npred(in_tdata[95:64]), .tpred(in_tdata[127:96]), .first(in_tuser[2]),
    .last(in_tlast), .adv_o(a), .ret_o(r), .tgt_o(t), .frac_o(f),
    .last_o(out_tlast));

  assign out_tvalid = vld_r;
  assign out_tdata = {7'd0, f, t, r, a};
endmodule
`default_nettype wire

[verif/tb_generalized_advantage_estimator_unit.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb_generalized_advantage_estimator_unit;

  localparam int FB = 16;
  localparam longint TOT_MAX = (64'd1 << 48) - 1;

  typedef struct packed {
    logic [31:0] reward;
    logic [1:0]  kind;
    logic [31:0] vpred;
    logic [31:0] npred;
    logic [31:0] tpred;
    logic        first;
    logic        last;
  } step_t;

  typedef struct packed {
    logic [31:0] adv;
    logic [31:0] ret;
    logic [31:0] target;
    logic [16:0] frac;
    logic        last;
  } gae_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [30:0] cfg_wdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic out_tlast;

  generalized_advantage_estimator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #6 clk = ~clk;

  // predictor state
  longint gamma_q, lambda_q, recip_q, clip_q;
  longint run_adv, run_ret;
  longint tot_abs, tot_clipped;

  step_t pending_steps[$];
  gae_result_t expected_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_last = 0;
  bit hold_sender = 1'b0;
  bit long_stall_req = 1'b0;

  function automatic longint fl_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-(v + 1)) >>> s) - 1;
  endfunction

  function automatic longint rnd(longint p);
    return fl_shift(p + (64'sd1 <<< (FB - 1)), FB);
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint add_total(longint t, longint v);
    if (v > TOT_MAX - t) return TOT_MAX;
    return t + v;
  endfunction

  function automatic longint iabs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic gae_result_t estimate_step(step_t st);
    gae_result_t r;
    longint rw, vp, s, nxt, delta, adv, ret;
    logic [63:0] num, rem, q;
    bit done, trunc;
    rw = longint'(signed'(st.reward));
    vp = longint'(signed'(st.vpred));
    done = st.kind == gae_pkg::KIND_DONE;
    trunc = st.kind == gae_pkg::KIND_TRUNC;
    if (st.first) begin
      run_adv = 0; run_ret = 0; tot_abs = 0; tot_clipped = 0;
    end
    if (recip_q != 0) begin
      s = sat32(rnd(rw * recip_q));
      tot_abs = add_total(tot_abs, iabs(s));
      if (clip_q != 0) begin
        if (s > clip_q) s = clip_q;
        if (s < -clip_q) s = -clip_q;
      end
      tot_clipped = add_total(tot_clipped, iabs(s));
    end else begin
      s = rw;
      tot_abs = add_total(tot_abs, iabs(rw));
      tot_clipped = add_total(tot_clipped, iabs(rw));
    end
    if (trunc) nxt = longint'(signed'(st.tpred));
    else if (done) nxt = 0;
    else nxt = longint'(signed'(st.npred));
    delta = s + rnd(gamma_q * nxt) - vp;
    if (done || trunc) begin
      adv = sat32(delta);
      ret = rw;
    end else begin
      adv = sat32(delta + rnd(rnd(gamma_q * lambda_q) * run_adv));
      ret = sat32(rw + rnd(run_ret * gamma_q));
    end
    run_adv = adv;
    run_ret = ret;
    r.adv = adv[31:0];
    r.ret = ret[31:0];
    r.target = 32'(sat32(vp + adv));
    r.frac = '0;
    if (st.last && tot_abs != 0) begin
      num = tot_abs - tot_clipped;
      q = (num >= tot_abs) ? 64'd1 : 64'd0;
      rem = q[0] ? num - tot_abs : num;
      for (int i = 0; i < FB; i++) begin
        q = q << 1;
        rem = rem << 1;
        if (rem >= tot_abs) begin
          rem = rem - tot_abs;
          q[0] = 1'b1;
        end
      end
      r.frac = q[16:0];
    end
    r.last = st.last;
    return r;
  endfunction

  // sampled handshake state, captured at the rising edge
  bit in_tready_q = 1'b0;
  always @(posedge clk) in_tready_q <= in_tvalid & in_tready;

  // driver: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready_q) begin
        expected_results.push_back(estimate_step(pending_steps.pop_front()));
        n_sent++;
      end
      if (in_tvalid && !in_tready_q) begin
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_steps.size() > 0 && !hold_sender) begin
        in_tvalid <= 1'b1;
        in_tdata <= {pending_steps[0].tpred, pending_steps[0].npred,
                     pending_steps[0].vpred, pending_steps[0].reward};
        in_tuser <= {pending_steps[0].first, pending_steps[0].kind};
        in_tlast <= pending_steps[0].last;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  int stall_phase = 0;
  int long_hold = 0;
  always @(negedge clk) begin
    if (long_stall_req && long_hold == 0) begin
      long_hold = 200;
      long_stall_req = 1'b0;
    end
    if (long_hold > 0) begin
      long_hold--;
      out_tready <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 23;
      if (stall_phase < 8) out_tready <= 1'b1;
      else out_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    gae_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.adv = out_tdata[31:0];
      got.ret = out_tdata[63:32];
      got.target = out_tdata[95:64];
      got.frac = out_tdata[112:96];
      got.last = out_tlast;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (got.last) n_last++;
        if (got.adv !== want.adv) begin
          $display("%0t: advantage exp %h got %h", $time, want.adv, got.adv); errors++;
        end
        if (got.ret !== want.ret) begin
          $display("%0t: return exp %h got %h", $time, want.ret, got.ret); errors++;
        end
        if (got.target !== want.target) begin
          $display("%0t: target exp %h got %h", $time, want.target, got.target); errors++;
        end
        if (got.frac !== want.frac) begin
          $display("%0t: clip fraction exp %h got %h", $time, want.frac, got.frac); errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: tlast exp %b got %b", $time, want.last, got.last); errors++;
        end
        if (out_tdata[119:113] !== '0) begin
          $display("%0t: fill exp 0 got %h", $time, out_tdata[119:113]); errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(signed'($urandom_range(0, 2 ** 20)) - 2 ** 19);
      3: return $urandom;
      default: return 32'(signed'($urandom_range(0, 2 ** 22)) - 2 ** 21);
    endcase
  endfunction

  task automatic add_step(logic [31:0] rw, gae_pkg::kind_t k, logic [31:0] vp,
                          logic [31:0] np, logic [31:0] tp, bit f, bit l);
    step_t st;
    st.reward = rw; st.kind = k; st.vpred = vp; st.npred = np; st.tpred = tp;
    st.first = f; st.last = l;
    pending_steps.push_back(st);
  endtask

  task automatic add_batch(int len);
    for (int i = 0; i < len; i++)
      add_step(rand_val(),
               gae_pkg::kind_t'(($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0),
               rand_val(), rand_val(), rand_val(), i == 0, i == len - 1);
  endtask

  task automatic drain();
    while (pending_steps.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(gae_pkg::reg_idx_t idx, logic [30:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gae_pkg::REG_DISCOUNT: gamma_q = val[16:0];
      gae_pkg::REG_DECAY:    lambda_q = val[16:0];
      gae_pkg::REG_RECIP:    recip_q = val;
      gae_pkg::REG_CLIP:     clip_q = val;
    endcase
  endtask

  initial begin
    gamma_q = 65208; lambda_q = 62259; recip_q = 0; clip_q = 0;
    run_adv = 0; run_ret = 0; tot_abs = 0; tot_clipped = 0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // defaults, every kind, field extremes
    add_step(32'h0001_0000, gae_pkg::KIND_NONE, 32'h0, 32'h0002_0000, 32'h0, 1, 0);
    add_step(32'h7FFF_FFFF, gae_pkg::KIND_NONE, 32'h8000_0000, 32'h7FFF_FFFF,
             32'hFFFF_FFFF, 0, 0);
    add_step(32'h8000_0000, gae_pkg::KIND_DONE, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h1234_5678, 0, 0);
    add_step(32'hFFFF_0000, gae_pkg::KIND_TRUNC, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    add_step(32'h0000_8000, gae_pkg::KIND_SPARE, 32'h0001_0000, 32'h0003_0000, 32'h0, 0, 1);
    add_step(32'h0, gae_pkg::KIND_NONE, 32'h0, 32'h0, 32'h0, 1, 1);
    drain();

    // standardization on, clipping off
    write_reg(gae_pkg::REG_RECIP, 31'h0000_8000);
    add_step(32'h0004_0000, gae_pkg::KIND_NONE, 32'h0, 32'h0001_0000, 32'h0, 1, 0);
    add_step(32'h8000_0000, gae_pkg::KIND_TRUNC, 32'h0, 32'h0, 32'h8000_0000, 0, 1);
    drain();
    // clipping, large recip, extreme factors
    write_reg(gae_pkg::REG_CLIP, 31'h0001_0000);
    write_reg(gae_pkg::REG_RECIP, 31'h7FFF_FFFF);
    write_reg(gae_pkg::REG_DISCOUNT, 31'd65536);
    write_reg(gae_pkg::REG_DECAY, 31'd65536);
    add_step(32'h0000_0100, gae_pkg::KIND_NONE, 32'h0, 32'h7FFF_FFFF, 32'h0, 1, 0);
    add_step(32'hFFFF_FF00, gae_pkg::KIND_NONE, 32'h8000_0000, 32'h8000_0000, 32'h0, 0, 0);
    add_step(32'h7FFF_FFFF, gae_pkg::KIND_NONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 0, 1);
    drain();
    write_reg(gae_pkg::REG_DISCOUNT, 31'd0);
    write_reg(gae_pkg::REG_DECAY, 31'd0);
    write_reg(gae_pkg::REG_CLIP, 31'h7FFF_FFFF);
    add_step(32'h0000_0000, gae_pkg::KIND_NONE, 32'h0, 32'h0, 32'h0, 1, 1);
    add_step(32'h0005_0000, gae_pkg::KIND_NONE, 32'h1, 32'h7, 32'h0, 1, 1);
    drain();

    // random phases with different settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(gae_pkg::REG_DISCOUNT, 31'($urandom_range(60000, 65536)));
      write_reg(gae_pkg::REG_DECAY, 31'($urandom_range(0, 65536)));
      write_reg(gae_pkg::REG_RECIP,
                (ph % 3 == 0) ? 31'd0 : 31'($urandom_range(1, 2 ** 18)));
      write_reg(gae_pkg::REG_CLIP,
                (ph % 2 == 0) ? 31'd0 : 31'($urandom_range(1, 2 ** 18)));
      if (ph == 2) long_stall_req = 1'b1;
      while (pending_steps.size() < 60) add_batch($urandom_range(1, 12));
      while (pending_steps.size() > 0) @(posedge clk);
      if (ph == 4) begin
        hold_sender = 1'b1;
        add_batch(8);
        while (expected_results.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end

    $display("Covered %0d steps with %0d checked results and %0d batch ends,",
             n_sent, n_checked, n_last);
    $display("over default, scaled, clipped and extreme discount settings.");
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
